[design/mste_pkg.sv]
// Package for the Morse symbol timing encoder: shared constants, types,
// the character table and its lookup function. No dependencies.
package mste_pkg;

   localparam int MAX_ELEMENTS = 8;
   localparam int K_W          = $clog2(MAX_ELEMENTS);
   localparam int CHAR_W       = 8;
   localparam int CFG_W        = 14;
   localparam int OUT_W        = 16;
   localparam int ADDR_W       = 5;
   localparam int DATA_W       = 32;
   localparam int CODE_COUNT   = 94;

   localparam logic [CHAR_W-1:0] FIRST_CODE = 8'h21;
   localparam logic [CHAR_W-1:0] LAST_CODE  = 8'h7E;

   // Register map, indexed by paddr[4:2].
   typedef enum logic [2:0] {
      REG_DOT_LENGTH  = 3'd0,
      REG_DASH_LENGTH = 3'd1,
      REG_ELEMENT_GAP = 3'd2,
      REG_LETTER_GAP  = 3'd3,
      REG_WORD_GAP    = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] dot_length;
      logic [CFG_W-1:0] dash_length;
      logic [CFG_W-1:0] element_gap;
      logic [CFG_W-1:0] letter_gap;
      logic [CFG_W-1:0] word_gap;
   } cfg_type;

   typedef struct packed {
      logic                    silent;
      logic [K_W-1:0]          last_idx;
      logic [MAX_ELEMENTS-1:0] pattern;
   } symbol_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_final;
      logic out_free;
   } dp_status_type;

   // Element count per printable code, starting at '!'.
   localparam logic [7:0] ELEM_COUNT [CODE_COUNT] = '{
      6, 6, 5, 7, 8, 5, 6, 5, 6, 7, 5, 6, 6, 6, 5,
      5, 5, 5, 5, 5, 5, 5, 5, 5, 5,
      6, 6, 7, 5, 6, 6, 6,
      2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4,
      5, 6, 6, 7, 6, 6,
      2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4,
      5, 6, 6, 8
   };

   // Element pattern per printable code, LSB first, a one is a dash.
   localparam logic [7:0] ELEM_BITS [CODE_COUNT] = '{
      53, 18, 29, 72, 86, 2, 30, 13, 45, 40, 10, 51, 33, 42, 9,
      31, 30, 28, 24, 16, 0, 1, 3, 7, 15,
      7, 21, 2, 17, 3, 12, 22,
      2, 1, 5, 1, 0, 4, 3, 0, 0, 14, 5, 2, 3, 1, 7, 6, 11, 2, 0, 1, 4, 8, 6, 9, 13, 3,
      13, 40, 45, 96, 44, 30,
      2, 1, 5, 1, 0, 4, 3, 0, 0, 14, 5, 2, 3, 1, 7, 6, 11, 2, 0, 1, 4, 8, 6, 9, 13, 3,
      13, 30, 45, 37
   };

   function automatic symbol_type lookup_symbol(input logic [CHAR_W-1:0] ch);
      symbol_type  sym;
      logic [6:0]  idx;
      logic [7:0]  cnt;
      sym = '0;
      idx = 7'(ch - FIRST_CODE);
      cnt = 8'd1;
      if ((ch < FIRST_CODE) || (ch > LAST_CODE)) begin
         sym.silent = 1'b1;
      end else begin
         cnt = ELEM_COUNT[idx];
         if (cnt > 8'(MAX_ELEMENTS)) begin
            cnt = 8'(MAX_ELEMENTS);
         end
         if (cnt == 8'd0) begin
            cnt = 8'd1;
         end
         sym.last_idx = K_W'(cnt - 8'd1);
         sym.pattern  = MAX_ELEMENTS'(ELEM_BITS[idx]);
      end
      return sym;
   endfunction

endpackage

[design/mste_if.sv]
// Handshake interfaces for the request (character) and response (element)
// channels of the Morse encoder. Depends on mste_pkg.
interface mste_req_if;
   logic                       valid;
   logic                       ready;
   logic [mste_pkg::CHAR_W-1:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface mste_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mste_pkg::OUT_W-1:0] period;
   logic [mste_pkg::OUT_W-1:0] pulse;
   logic                       last;

   modport source (output valid, output period, output pulse, output last, input ready);
   modport sink   (input valid, input period, input pulse, input last, output ready);
endinterface

[design/mste_regs.sv]
// APB-style register file holding the five timing registers.
// Depends on mste_pkg.
module mste_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mste_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mste_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mste_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output mste_pkg::cfg_type             cfg
);
   import mste_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             wr_en;
   reg_index_type    idx;
   logic [CFG_W-1:0] wdata;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wdata      = csr_pwdata[CFG_W-1:0];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DOT_LENGTH:  cfg_in.dot_length  = wdata;
            REG_DASH_LENGTH: cfg_in.dash_length = wdata;
            REG_ELEMENT_GAP: cfg_in.element_gap = wdata;
            REG_LETTER_GAP:  cfg_in.letter_gap  = wdata;
            REG_WORD_GAP:    cfg_in.word_gap    = wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_DOT_LENGTH:  csr_prdata = DATA_W'(cfg_ff.dot_length);
         REG_DASH_LENGTH: csr_prdata = DATA_W'(cfg_ff.dash_length);
         REG_ELEMENT_GAP: csr_prdata = DATA_W'(cfg_ff.element_gap);
         REG_LETTER_GAP:  csr_prdata = DATA_W'(cfg_ff.letter_gap);
         REG_WORD_GAP:    csr_prdata = DATA_W'(cfg_ff.word_gap);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_length  <= CFG_W'(100);
         cfg_ff.dash_length <= CFG_W'(300);
         cfg_ff.element_gap <= CFG_W'(100);
         cfg_ff.letter_gap  <= CFG_W'(200);
         cfg_ff.word_gap    <= CFG_W'(600);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/mste_dp.sv]
// Datapath: latches the looked-up symbol, steps through its elements and
// holds the response output register. Depends on mste_pkg.
module mste_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  mste_pkg::dp_cmd_type          cmd,
   input  mste_pkg::cfg_type             cfg,
   input  logic [mste_pkg::CHAR_W-1:0]   req_character,
   input  logic                          rsp_ready,
   output mste_pkg::dp_status_type       status,
   output logic                          rsp_valid,
   output logic [mste_pkg::OUT_W-1:0]    rsp_period,
   output logic [mste_pkg::OUT_W-1:0]    rsp_pulse,
   output logic                          rsp_last
);
   import mste_pkg::*;

   symbol_type       sym_ff, sym_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic             out_valid_ff, out_valid_in;
   logic [OUT_W-1:0] period_ff, period_in;
   logic [OUT_W-1:0] pulse_ff, pulse_in;
   logic             last_ff, last_in;

   logic             is_final;
   logic             use_dash;
   logic [CFG_W-1:0] len;
   logic [CFG_W-1:0] gap;
   logic [CFG_W-1:0] extra;

   assign is_final = sym_ff.silent || (k_ff == sym_ff.last_idx);
   assign status.is_final = is_final;
   assign status.out_free = !out_valid_ff || rsp_ready;

   // A silent symbol uses the dash length as the base of its period.
   always_comb begin
      use_dash = sym_ff.silent || sym_ff.pattern[k_ff];
      len      = use_dash ? cfg.dash_length : cfg.dot_length;
      gap      = sym_ff.silent ? cfg.word_gap : cfg.element_gap;
      extra    = (is_final && !sym_ff.silent) ? cfg.letter_gap : '0;
      period_in = OUT_W'(len) + OUT_W'(gap) + OUT_W'(extra);
      pulse_in  = sym_ff.silent ? '0 : OUT_W'(len);
      last_in   = is_final;
   end

   always_comb begin
      sym_in = cmd.load ? lookup_symbol(req_character) : sym_ff;
      k_in   = k_ff;
      if (cmd.load) begin
         k_in = '0;
      end else if (cmd.emit) begin
         k_in = k_ff + K_W'(1);
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      if (cmd.emit) begin
         period_ff <= period_in;
         pulse_ff  <= pulse_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_period = period_ff;
   assign rsp_pulse  = pulse_ff;
   assign rsp_last   = last_ff;

endmodule

[design/mste_ctrl.sv]
// Controller state machine: accepts a character, then issues one emit
// per element while the output register can take it. Depends on mste_pkg.
module mste_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mste_pkg::dp_status_type status,
   output mste_pkg::dp_cmd_type    cmd
);
   import mste_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.out_free && status.is_final) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_final_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && status.out_free && status.is_final) |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after the final element");

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_RUN)
      else $error("accepted character did not start a run");

   a_emit_needs_space: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit issued while the output register was full");

endmodule

[design/morse_symbol_timing_encoder.sv]
// Top level of the Morse symbol timing encoder: register file, controller
// and datapath. Depends on mste_pkg, mste_if, mste_regs, mste_ctrl, mste_dp.

// Each accepted character produces a run of keying transactions on the
// response channel, one per Morse element: pulse is the key-on time (dot or
// dash length) and period adds the element gap, plus the letter gap on the
// element marked last. Printable bytes from '!' to '~' come from a fixed table
// (lower case shares the upper-case codes); any other byte, space included,
// gives a single silent transaction of word gap plus dash length with pulse
// zero. The controller first accepts and looks up the character, then, for
// each element, steps the element counter and loads the single output
// register whenever that register is free. The output register lets the
// last element wait on the response channel while the next character is
// accepted. The timing registers sit on the APB port at byte addresses
// 0x00 (dot), 0x04 (dash), 0x08 (element gap), 0x0C (letter gap) and 0x10
// (word gap), 14 bits each, and should be written only while no character
// is in flight.
module morse_symbol_timing_encoder (
   input  logic                          clock,
   input  logic                          reset,
   mste_req_if.sink                      req_ch,
   mste_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mste_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mste_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mste_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import mste_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Timing registers.
   mste_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The controller owns the request handshake and sequences the elements.
   mste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath computes each element and drives the response channel.
   mste_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .req_character (req_ch.character),
      .rsp_ready     (rsp_ch.ready),
      .status        (status),
      .rsp_valid     (rsp_ch.valid),
      .rsp_period    (rsp_ch.period),
      .rsp_pulse     (rsp_ch.pulse),
      .rsp_last      (rsp_ch.last)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for morse_symbol_timing_encoder: predicts the keying
// transactions of each character and compares them against the response channel.
// Depends on mste_pkg, mste_req_if, mste_rsp_if and the encoder RTL.
module tb;
   import mste_pkg::*;

   // One keying transaction as it should appear on the response channel.
   typedef struct {
      logic [OUT_W-1:0] period;
      logic [OUT_W-1:0] pulse;
      logic             last;
   } keying_type;

   localparam int REG_SLOTS = 1 << (ADDR_W - 2);
   localparam logic [CFG_W-1:0] CFG_MAX = '1;
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] DEL_CHAR = 8'h7F;
   // Quiet cycles waited after the final transaction, so that the encoder is
   // certainly idle.
   localparam int SETTLE_CYCLES = 12;

   logic clock = 1'b0;
   logic reset;

   mste_req_if req_ch ();
   mste_rsp_if rsp_ch ();

   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [ADDR_W-1:0]   csr_paddr;
   logic [DATA_W-1:0]   csr_pwdata;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // The testbench's own copy of the timing registers, kept in step with
   // every write that goes out on the configuration port.
   cfg_type timing_cfg;

   // Keying transactions still owed by the encoder, oldest first.
   keying_type expected_keying[$];

   int error_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   morse_symbol_timing_encoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch.sink),
      .rsp_ch      (rsp_ch.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the encoder hangs. A correct run finishes in a small
   // fraction of this time, even with the heaviest response stalls.
   initial begin
      #8ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Works out the keying transactions of one character from the current
   // timing registers and appends them to the expected queue. Characters
   // outside the printable table give one silent transaction of word gap plus
   // dash length; table entries give one transaction per element, the pattern
   // read from its least significant bit with a one meaning a dash.
   task automatic predict_keying(input logic [CHAR_W-1:0] ch);
      keying_type       ev;
      int               elements;
      logic [7:0]       pattern;
      logic [OUT_W-1:0] len;
      if (ch < FIRST_CODE || ch > LAST_CODE) begin
         ev.period = OUT_W'(timing_cfg.word_gap) + OUT_W'(timing_cfg.dash_length);
         ev.pulse  = '0;
         ev.last   = 1'b1;
         expected_keying.push_back(ev);
      end else begin
         elements = ELEM_COUNT[ch - FIRST_CODE];
         pattern  = ELEM_BITS[ch - FIRST_CODE];
         if (elements > MAX_ELEMENTS) begin
            elements = MAX_ELEMENTS;
         end
         if (elements == 0) begin
            elements = 1;
         end
         for (int k = 0; k < elements; k++) begin
            len = pattern[k] ? OUT_W'(timing_cfg.dash_length) : OUT_W'(timing_cfg.dot_length);
            ev.pulse  = len;
            ev.period = len + OUT_W'(timing_cfg.element_gap);
            ev.last   = (k == elements - 1);
            if (ev.last) begin
               ev.period += OUT_W'(timing_cfg.letter_gap);
            end
            expected_keying.push_back(ev);
         end
      end
   endtask

   // Offers one character on the request channel, after idling for each
   // cycle in which the idle rate says so, and returns at the edge where the
   // transaction is accepted. Valid stays high into the next call so that
   // back-to-back characters need no bubble.
   task automatic send_character(input logic [CHAR_W-1:0] ch);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.character <= ch;
      do begin
         @(posedge clock);
      end while (!(req_ch.valid && req_ch.ready));
      predict_keying(ch);
   endtask

   // Drops valid and waits until every owed transaction has come back, then
   // lets the encoder settle so that register writes find it idle.
   task automatic drain_encoder();
      req_ch.valid <= 1'b0;
      while (expected_keying.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB write: a setup cycle, then an access cycle that completes at the
   // edge where pready is seen high. Slots past the word gap register are
   // unmapped and must leave the timing untouched.
   task automatic write_register(input int index, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (reg_index_type'(index))
         REG_DOT_LENGTH:  timing_cfg.dot_length  = value[CFG_W-1:0];
         REG_DASH_LENGTH: timing_cfg.dash_length = value[CFG_W-1:0];
         REG_ELEMENT_GAP: timing_cfg.element_gap = value[CFG_W-1:0];
         REG_LETTER_GAP:  timing_cfg.letter_gap  = value[CFG_W-1:0];
         REG_WORD_GAP:    timing_cfg.word_gap    = value[CFG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all_registers(input logic [DATA_W-1:0] dot, input logic [DATA_W-1:0] dash,
                                      input logic [DATA_W-1:0] egap, input logic [DATA_W-1:0] lgap,
                                      input logic [DATA_W-1:0] wgap);
      write_register(REG_DOT_LENGTH, dot);
      write_register(REG_DASH_LENGTH, dash);
      write_register(REG_ELEMENT_GAP, egap);
      write_register(REG_LETTER_GAP, lgap);
      write_register(REG_WORD_GAP, wgap);
   endtask

   // Random register value: zero and the 14-bit maximum turn up often, and the
   // upper bits carry junk that the encoder has to drop.
   function automatic logic [DATA_W-1:0] random_timing();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) begin
         return {$urandom} & ~DATA_W'(CFG_MAX);
      end else if (pick == 1) begin
         return {$urandom} | DATA_W'(CFG_MAX);
      end else if (pick < 6) begin
         return DATA_W'($urandom_range(1, 1000));
      end
      return $urandom;
   endfunction

   // Mostly printable table characters, with spaces and arbitrary bytes mixed
   // in so that the silent path and its range edges are hit too.
   function automatic logic [CHAR_W-1:0] random_character();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return CHAR_W'($urandom_range(FIRST_CODE, LAST_CODE));
      end else if (pick < 80) begin
         return SPACE_CHAR;
      end else if (pick < 85) begin
         return (pick < 83) ? LAST_CODE + 1'b1 : FIRST_CODE - 1'b1;
      end
      return CHAR_W'($urandom);
   endfunction

   // Reset values of the timing registers, with the character table's edges,
   // an eight-element code, single-element letters, lower and upper case, and
   // the silent bytes around and outside the printable range.
   task automatic test_reset_timing();
      logic [CHAR_W-1:0] chars[$];
      chars = '{8'h21, 8'h25, 8'h45, 8'h54, 8'h41, 8'h61, 8'h30, 8'h7E,
                SPACE_CHAR, DEL_CHAR, 8'h00, 8'hFF};
      foreach (chars[i]) begin
         send_character(chars[i]);
      end
      drain_encoder();
   endtask

   // Extreme register settings: everything at the 14-bit maximum (the largest
   // sums), zero dot and dash lengths with zero gaps, and writes whose upper
   // bits are set. Writes to the unmapped slots come last and must not change
   // the timing seen on the following characters.
   task automatic test_register_extremes();
      write_all_registers(DATA_W'(CFG_MAX), DATA_W'(CFG_MAX), DATA_W'(CFG_MAX),
                          DATA_W'(CFG_MAX), DATA_W'(CFG_MAX));
      send_character(8'h25);
      send_character(SPACE_CHAR);
      send_character(8'h7E);
      drain_encoder();

      write_all_registers('0, '0, '0, '0, '0);
      send_character(8'h21);
      send_character(8'h80);
      drain_encoder();

      write_all_registers(32'hFFFF_C001, 32'hAAAA_8002, 32'h5555_4003, 32'h0001_0000,
                          32'hFFFF_FFFF);
      for (int i = int'(REG_WORD_GAP) + 1; i < REG_SLOTS; i++) begin
         write_register(i, $urandom);
      end
      send_character(8'h3F);
      send_character(8'h7A);
      send_character(8'h1F);
      drain_encoder();
   endtask

   // Random characters under two random timings, with the given
   // idle and stall rates on the two channels.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int setting = 0; setting < 2; setting++) begin
         write_all_registers(random_timing(), random_timing(), random_timing(),
                             random_timing(), random_timing());
         for (int n = 0; n < count / 2; n++) begin
            send_character(random_character());
         end
         drain_encoder();
      end
   endtask

   // Response side: ready follows the current stall rate, and each accepted
   // transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      keying_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_keying.size() == 0) begin
               report_mismatch("unexpected keying transaction count", 1, 0);
            end else begin
               want = expected_keying.pop_front();
               if (rsp_ch.period !== want.period) begin
                  report_mismatch("period", rsp_ch.period, want.period);
               end
               if (rsp_ch.pulse !== want.pulse) begin
                  report_mismatch("pulse", rsp_ch.pulse, want.pulse);
               end
               if (rsp_ch.last !== want.last) begin
                  report_mismatch("last", rsp_ch.last, want.last);
               end
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.character = '0;
      rsp_ch.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      timing_cfg.dot_length  = CFG_W'(100);
      timing_cfg.dash_length = CFG_W'(300);
      timing_cfg.element_gap = CFG_W'(100);
      timing_cfg.letter_gap  = CFG_W'(200);
      timing_cfg.word_gap    = CFG_W'(600);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs with a mild random pattern on both channels.
      sender_idle_pct    = 20;
      receiver_stall_pct = 30;
      test_reset_timing();
      test_register_extremes();

      // Slow receiver first, then a slow sender, then both at full rate.
      test_random_traffic(23, 82, 126);
      test_random_traffic(82, 23, 126);
      test_random_traffic(0, 0, 128);

      drain_encoder();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

[sim.f]
design/mste_pkg.sv
design/mste_if.sv
design/mste_regs.sv
design/mste_dp.sv
design/mste_ctrl.sv
design/morse_symbol_timing_encoder.sv
tb/tb.sv
